/* rtl/assert_macros.svh */
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define SVR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define SVR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/svr_pkg.sv */
`timescale 1ns / 1ps

package svr_pkg;

   localparam int OPERATION_W = 2;
   localparam int VELOCITY_W  = 16;
   localparam int SPEED_W     = 16;
   localparam int PERIOD_W    = 32;
   localparam int COMPARE_W   = 31;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // Shared arithmetic units: 32 x 16 multiplier, 48 / 32 divider.
   localparam int MUL_A_W    = 32;
   localparam int MUL_B_W    = 16;
   localparam int PRODUCT_W  = MUL_A_W + MUL_B_W;
   localparam int DIVIDEND_W = PRODUCT_W;
   localparam int DIVISOR_W  = 32;

   localparam int RPM_SECONDS = 60;

   typedef enum logic [OPERATION_W-1:0] {
      OP_SET_VELOCITY = 2'd0,
      OP_TICK         = 2'd1,
      OP_DRIVE_ON     = 2'd2,
      OP_DRIVE_OFF    = 2'd3
   } svr_op_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_PULSES_PER_REV = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEL_COEF     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_SPEED      = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_SPEED      = 2'd3;

endpackage

/* rtl/svr_if.sv */
`timescale 1ns / 1ps

interface svr_req_if import svr_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic [OPERATION_W-1:0]        operation;
   logic signed [VELOCITY_W-1:0]  velocity;

   modport source (output valid, output operation, output velocity, input ready);
   modport sink   (input valid, input operation, input velocity, output ready);
endinterface

interface svr_rsp_if import svr_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       accepted;
   logic                       enable_out;
   logic                       direction_out;
   logic                       pulse_running;
   logic                       tick_running;
   logic [PERIOD_W-1:0]        period_reload;
   logic [COMPARE_W-1:0]       pulse_compare;
   logic signed [SPEED_W-1:0]  speed_rpm;

   modport source (
      output valid, output accepted, output enable_out, output direction_out,
      output pulse_running, output tick_running, output period_reload,
      output pulse_compare, output speed_rpm, input ready
   );
   modport sink (
      input valid, input accepted, input enable_out, input direction_out,
      input pulse_running, input tick_running, input period_reload,
      input pulse_compare, input speed_rpm, output ready
   );
endinterface

/* rtl/stepper_velocity_ramp_unit.sv */
`timescale 1ns / 1ps

// Stepper pulse-period ramp generator. Each request item is drive on, drive off, set a signed
// target speed in rpm, or a period-elapsed tick, and each produces exactly one response item
// with the driver enable, direction pin, pulse and tick run flags, the timer reload value
// (period minus one), the pulse compare value (half period minus one) and the signed speed.
// On a tick the current period is scaled by accel_coef / ACCEL_RESOLUTION (by its inverse
// when it shrinks) toward the target period; a reversal first slows to the minimum-speed period
// and then flips direction. All arithmetic runs on one bit-serial 48 / 32 divider (48 steps)
// and one shift-add 32 x 16 multiplier (16 steps), used one after the other. Drive on, drive
// off, a rejected or dead-band target and an idle tick use neither unit; an accepted target
// takes two divisions and one multiplication; a tick takes two divisions and one multiplication
// to check the target and five divisions and three multiplications to move the period. One
// item is worked at a time; a new item is taken while the previous response still waits in
// the output register. Registers must be written by the user through the csr port only while
// the block is idle; the block does not enforce it. A register written as zero acts as one.
module stepper_velocity_ramp_unit import svr_pkg::*; #(
   parameter int TIMER_CLOCK_HZ   = 1000000,
   parameter int ACCEL_RESOLUTION = 1000
) (
   input  logic                   clock,
   input  logic                   reset,
   svr_req_if.sink                req_chan,
   svr_rsp_if.source              rsp_chan,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int PprReset      = 200;
   localparam int CoefReset     = 1010;
   localparam int MinSpeedReset = 10;
   localparam int MaxSpeedReset = 3000;
   localparam int SpeedMax      = 32767;

   function automatic logic [PERIOD_W-1:0] clamp_period(input logic [DIVIDEND_W-1:0] p);
      logic [PERIOD_W-1:0] r;
      if (p < DIVIDEND_W'(2)) begin
         r = PERIOD_W'(2);
      end else if (p > DIVIDEND_W'({PERIOD_W{1'b1}})) begin
         r = {PERIOD_W{1'b1}};
      end else begin
         r = p[PERIOD_W-1:0];
      end
      return r;
   endfunction

   localparam longint ResetRaw =
      (longint'(TIMER_CLOCK_HZ) / MinSpeedReset) * RPM_SECONDS / PprReset;
   localparam logic [PERIOD_W-1:0]   ResetPeriod  = clamp_period(DIVIDEND_W'(ResetRaw));
   localparam logic [DIVIDEND_W-1:0] TclkDividend = DIVIDEND_W'(TIMER_CLOCK_HZ);
   localparam logic [DIVISOR_W-1:0]  ResDivisor   = DIVISOR_W'(ACCEL_RESOLUTION);
   localparam logic [MUL_B_W-1:0]    ResFactor    = MUL_B_W'(ACCEL_RESOLUTION);
   localparam logic [MUL_B_W-1:0]    SecFactor    = MUL_B_W'(RPM_SECONDS);

   typedef enum logic [3:0] {
      ST_IDLE, ST_T_DIV1, ST_T_DIV2, ST_T_MUL,
      ST_M_DIV1, ST_M_MUL, ST_M_DIV2, ST_DECIDE,
      ST_R_MUL, ST_R_DIV, ST_APPLY,
      ST_W_DIV1, ST_W_MUL, ST_W_DIV2, ST_SPEED, ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      RM_REVERSE, RM_DECEL, RM_ACCEL
   } ramp_mode_type;

   // Sequencer and block state.
   state_type           state_ff, state_in;
   logic                launched_ff, launched_in;
   logic [DIVIDEND_W-1:0] work_ff, work_in;
   logic [PERIOD_W-1:0] minp_ff, minp_in;
   logic [14:0]         mag_ff, mag_in;
   ramp_mode_type       mode_ff, mode_in;
   logic                acc_ff, acc_in;
   logic                enabled_ff, enabled_in;
   logic                dir_now_ff, dir_now_in;
   logic                dir_wanted_ff, dir_wanted_in;
   logic                dir_pin_ff, dir_pin_in;
   logic                pulses_ff, pulses_in;
   logic                ticks_ff, ticks_in;
   logic [PERIOD_W-1:0] target_ff, target_in;
   logic [PERIOD_W-1:0] cur_ff, cur_in;
   logic [SPEED_W-1:0]  speed_ff, speed_in;

   // Configuration registers.
   logic [15:0] ppr_ff, ppr_in;
   logic [15:0] coef_ff, coef_in;
   logic [9:0]  ms_ff, ms_in;
   logic [14:0] maxs_ff, maxs_in;
   logic [15:0] ppr_nz, coef_nz;
   logic [9:0]  ms_nz;
   logic [14:0] maxs_nz;

   // Response register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_acc_ff, rsp_acc_in;
   logic                 rsp_en_ff, rsp_en_in;
   logic                 rsp_dir_ff, rsp_dir_in;
   logic                 rsp_pulse_ff, rsp_pulse_in;
   logic                 rsp_tick_ff, rsp_tick_in;
   logic [PERIOD_W-1:0]  rsp_reload_ff, rsp_reload_in;
   logic [COMPARE_W-1:0] rsp_compare_ff, rsp_compare_in;
   logic [SPEED_W-1:0]   rsp_speed_ff, rsp_speed_in;

   // Arithmetic units.
   logic                  div_start, div_done;
   logic [DIVIDEND_W-1:0] div_dividend, div_quotient;
   logic [DIVISOR_W-1:0]  div_divisor;
   logic                  mul_start, mul_done;
   logic [MUL_A_W-1:0]    mul_a;
   logic [MUL_B_W-1:0]    mul_b;
   logic [PRODUCT_W-1:0]  mul_product;

   // Request decode.
   logic                req_fire;
   svr_op_type          op_code;
   logic [16:0]         vel_ext;
   logic [16:0]         vel_mag;
   logic                vel_neg;
   logic                dead_band;
   logic [14:0]         mag_clamped;
   logic [DIVIDEND_W-1:0] ramp_next;
   logic [14:0]         speed_mag;
   logic [SPEED_W-1:0]  speed_pos;

   svr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   svr_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .done    (mul_done),
      .product (mul_product)
   );

   assign ppr_nz  = (ppr_ff == '0) ? 16'd1 : ppr_ff;
   assign coef_nz = (coef_ff == '0) ? 16'd1 : coef_ff;
   assign ms_nz   = (ms_ff == '0) ? 10'd1 : ms_ff;
   assign maxs_nz = (maxs_ff == '0) ? 15'd1 : maxs_ff;

   assign req_fire    = req_chan.valid && (state_ff == ST_IDLE);
   assign op_code     = svr_op_type'(req_chan.operation);
   assign vel_neg     = req_chan.velocity[VELOCITY_W-1];
   assign vel_ext     = {req_chan.velocity[VELOCITY_W-1], req_chan.velocity};
   assign vel_mag     = vel_neg ? (17'd0 - vel_ext) : vel_ext;
   assign dead_band   = (vel_mag < 17'(ms_nz));
   assign mag_clamped = (vel_mag > 17'(maxs_nz)) ? maxs_nz : vel_mag[14:0];

   assign speed_mag = (work_ff > DIVIDEND_W'(SpeedMax)) ? 15'(SpeedMax) : work_ff[14:0];
   assign speed_pos = {1'b0, speed_mag};

   // Operand selection for the shared units; each unit state launches once.
   always_comb begin
      div_dividend = work_ff;
      div_divisor  = DIVISOR_W'(ppr_nz);
      mul_a        = work_ff[MUL_A_W-1:0];
      mul_b        = SecFactor;
      div_start    = 1'b0;
      mul_start    = 1'b0;
      case (state_ff)
         ST_T_DIV1: begin
            div_dividend = TclkDividend;
            div_divisor  = DIVISOR_W'(mag_ff);
            div_start    = !launched_ff;
         end
         ST_M_DIV1: begin
            div_dividend = TclkDividend;
            div_divisor  = DIVISOR_W'(ms_nz);
            div_start    = !launched_ff;
         end
         ST_W_DIV1: begin
            div_dividend = TclkDividend;
            div_divisor  = DIVISOR_W'(cur_ff);
            div_start    = !launched_ff;
         end
         ST_T_DIV2, ST_M_DIV2, ST_W_DIV2: begin
            div_start = !launched_ff;
         end
         ST_R_DIV: begin
            div_divisor = (mode_ff == RM_DECEL) ? DIVISOR_W'(coef_nz) : ResDivisor;
            div_start   = !launched_ff;
         end
         ST_T_MUL, ST_M_MUL, ST_W_MUL: begin
            mul_start = !launched_ff;
         end
         ST_R_MUL: begin
            mul_a     = MUL_A_W'(cur_ff);
            mul_b     = (mode_ff == RM_DECEL) ? ResFactor : coef_nz;
            mul_start = !launched_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      work_in       = work_ff;
      minp_in       = minp_ff;
      mag_in        = mag_ff;
      mode_in       = mode_ff;
      acc_in        = acc_ff;
      enabled_in    = enabled_ff;
      dir_now_in    = dir_now_ff;
      dir_wanted_in = dir_wanted_ff;
      dir_pin_in    = dir_pin_ff;
      pulses_in     = pulses_ff;
      ticks_in      = ticks_ff;
      target_in     = target_ff;
      cur_in        = cur_ff;
      speed_in      = speed_ff;
      ramp_next     = work_ff;

      ppr_in  = ppr_ff;
      coef_in = coef_ff;
      ms_in   = ms_ff;
      maxs_in = maxs_ff;

      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_acc_in     = rsp_acc_ff;
      rsp_en_in      = rsp_en_ff;
      rsp_dir_in     = rsp_dir_ff;
      rsp_pulse_in   = rsp_pulse_ff;
      rsp_tick_in    = rsp_tick_ff;
      rsp_reload_in  = rsp_reload_ff;
      rsp_compare_in = rsp_compare_ff;
      rsp_speed_in   = rsp_speed_ff;

      if (csr_write_en) begin
         case (csr_index)
            CSR_PULSES_PER_REV: ppr_in  = csr_wdata;
            CSR_ACCEL_COEF:     coef_in = csr_wdata;
            CSR_MIN_SPEED:      ms_in   = csr_wdata[9:0];
            CSR_MAX_SPEED:      maxs_in = csr_wdata[14:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               acc_in   = 1'b0;
               state_in = ST_FINISH;
               case (op_code)
                  OP_DRIVE_ON: begin
                     enabled_in = 1'b1;
                  end
                  OP_DRIVE_OFF: begin
                     enabled_in = 1'b0;
                     pulses_in  = 1'b0;
                     ticks_in   = 1'b0;
                  end
                  OP_TICK: begin
                     if (ticks_ff) begin
                        state_in = ST_M_DIV1;
                     end
                  end
                  OP_SET_VELOCITY: begin
                     if (enabled_ff) begin
                        acc_in = 1'b1;
                        if (dead_band) begin
                           pulses_in = 1'b0;
                           ticks_in  = 1'b0;
                        end else begin
                           dir_pin_in    = !vel_neg;
                           dir_wanted_in = !vel_neg;
                           mag_in        = mag_clamped;
                           state_in      = ST_T_DIV1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         // Target period: clock / rpm / pulses_per_rev * 60.
         ST_T_DIV1: begin
            if (div_done) begin
               work_in  = div_quotient;
               state_in = ST_T_DIV2;
            end
         end
         ST_T_DIV2: begin
            if (div_done) begin
               work_in  = div_quotient;
               state_in = ST_T_MUL;
            end
         end
         ST_T_MUL: begin
            if (mul_done) begin
               target_in = clamp_period(mul_product);
               pulses_in = 1'b1;
               ticks_in  = 1'b1;
               state_in  = ST_FINISH;
            end
         end
         // Minimum-speed period: clock / slowest rpm * 60 / pulses_per_rev.
         ST_M_DIV1: begin
            if (div_done) begin
               work_in  = div_quotient;
               state_in = ST_M_MUL;
            end
         end
         ST_M_MUL: begin
            if (mul_done) begin
               work_in  = mul_product;
               state_in = ST_M_DIV2;
            end
         end
         ST_M_DIV2: begin
            if (div_done) begin
               minp_in  = clamp_period(div_quotient);
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (dir_wanted_ff != dir_now_ff) begin
               if (cur_ff >= minp_ff) begin
                  dir_now_in = dir_wanted_ff;
                  state_in   = ST_FINISH;
               end else begin
                  mode_in  = RM_REVERSE;
                  state_in = ST_R_MUL;
               end
            end else if (cur_ff == target_ff) begin
               ticks_in = 1'b0;
               if (cur_ff == minp_ff) begin
                  pulses_in = 1'b0;
                  speed_in  = '0;
               end
               state_in = ST_FINISH;
            end else if (cur_ff > target_ff) begin
               mode_in  = RM_DECEL;
               state_in = ST_R_MUL;
            end else begin
               mode_in  = RM_ACCEL;
               state_in = ST_R_MUL;
            end
         end
         ST_R_MUL: begin
            if (mul_done) begin
               work_in  = mul_product;
               state_in = ST_R_DIV;
            end
         end
         ST_R_DIV: begin
            if (div_done) begin
               work_in  = div_quotient;
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            // A reversal that would pass the slowest speed snaps to it and turns.
            case (mode_ff)
               RM_REVERSE: begin
                  if (work_ff > DIVIDEND_W'(minp_ff)) begin
                     ramp_next  = DIVIDEND_W'(minp_ff);
                     dir_now_in = dir_wanted_ff;
                  end
               end
               RM_DECEL: begin
                  if (work_ff < DIVIDEND_W'(target_ff)) begin
                     ramp_next = DIVIDEND_W'(target_ff);
                  end
               end
               default: begin
                  if (work_ff > DIVIDEND_W'(target_ff)) begin
                     ramp_next = DIVIDEND_W'(target_ff);
                  end
               end
            endcase
            cur_in   = clamp_period(ramp_next);
            state_in = ST_W_DIV1;
         end
         // Speed: clock / period * 60 / pulses_per_rev.
         ST_W_DIV1: begin
            if (div_done) begin
               work_in  = div_quotient;
               state_in = ST_W_MUL;
            end
         end
         ST_W_MUL: begin
            if (mul_done) begin
               work_in  = mul_product;
               state_in = ST_W_DIV2;
            end
         end
         ST_W_DIV2: begin
            if (div_done) begin
               work_in  = div_quotient;
               state_in = ST_SPEED;
            end
         end
         ST_SPEED: begin
            speed_in = dir_now_ff ? speed_pos : (SPEED_W'(0) - speed_pos);
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_acc_in     = acc_ff;
               rsp_en_in      = enabled_ff;
               rsp_dir_in     = dir_pin_ff;
               rsp_pulse_in   = pulses_ff;
               rsp_tick_in    = ticks_ff;
               rsp_reload_in  = cur_ff - 1'b1;
               rsp_compare_in = COMPARE_W'((cur_ff >> 1) - 1'b1);
               rsp_speed_in   = speed_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      launched_in = launched_ff;
      if (div_start || mul_start) begin
         launched_in = 1'b1;
      end
      if (div_done || mul_done) begin
         launched_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         launched_ff   <= 1'b0;
         enabled_ff    <= 1'b0;
         dir_now_ff    <= 1'b1;
         dir_wanted_ff <= 1'b1;
         dir_pin_ff    <= 1'b0;
         pulses_ff     <= 1'b0;
         ticks_ff      <= 1'b0;
         target_ff     <= ResetPeriod;
         cur_ff        <= ResetPeriod;
         speed_ff      <= '0;
         ppr_ff        <= 16'(PprReset);
         coef_ff       <= 16'(CoefReset);
         ms_ff         <= 10'(MinSpeedReset);
         maxs_ff       <= 15'(MaxSpeedReset);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         launched_ff   <= launched_in;
         enabled_ff    <= enabled_in;
         dir_now_ff    <= dir_now_in;
         dir_wanted_ff <= dir_wanted_in;
         dir_pin_ff    <= dir_pin_in;
         pulses_ff     <= pulses_in;
         ticks_ff      <= ticks_in;
         target_ff     <= target_in;
         cur_ff        <= cur_in;
         speed_ff      <= speed_in;
         ppr_ff        <= ppr_in;
         coef_ff       <= coef_in;
         ms_ff         <= ms_in;
         maxs_ff       <= maxs_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      work_ff        <= work_in;
      minp_ff        <= minp_in;
      mag_ff         <= mag_in;
      mode_ff        <= mode_in;
      acc_ff         <= acc_in;
      rsp_acc_ff     <= rsp_acc_in;
      rsp_en_ff      <= rsp_en_in;
      rsp_dir_ff     <= rsp_dir_in;
      rsp_pulse_ff   <= rsp_pulse_in;
      rsp_tick_ff    <= rsp_tick_in;
      rsp_reload_ff  <= rsp_reload_in;
      rsp_compare_ff <= rsp_compare_in;
      rsp_speed_ff   <= rsp_speed_in;
   end

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.accepted      = rsp_acc_ff;
   assign rsp_chan.enable_out    = rsp_en_ff;
   assign rsp_chan.direction_out = rsp_dir_ff;
   assign rsp_chan.pulse_running = rsp_pulse_ff;
   assign rsp_chan.tick_running  = rsp_tick_ff;
   assign rsp_chan.period_reload = rsp_reload_ff;
   assign rsp_chan.pulse_compare = rsp_compare_ff;
   assign rsp_chan.speed_rpm     = rsp_speed_ff;

endmodule

/* rtl/svr_div.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module svr_div import svr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CntW = $clog2(DIVIDEND_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CntW-1:0]       cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  den_ff, den_in;
   logic [DIVISOR_W:0]    rem_shift;
   logic                  fits;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIVIDEND_W-1]};
      fits      = (rem_shift >= {1'b0, den_ff});
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         // The dividend shifts out at the top while quotient bits enter below.
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? DIVISOR_W'(rem_shift - {1'b0, den_ff})
                       : rem_shift[DIVISOR_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntW'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/svr_mul.sv */
`timescale 1ns / 1ps

// Shift-and-add multiplier, one multiplier bit per cycle.
module svr_mul import svr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [MUL_A_W-1:0]   mul_a,
   input  logic [MUL_B_W-1:0]   mul_b,
   output logic                 done,
   output logic [PRODUCT_W-1:0] product
);

   localparam int CntW = $clog2(MUL_B_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CntW-1:0]      cnt_ff, cnt_in;
   logic [PRODUCT_W-1:0] acc_ff, acc_in;
   logic [PRODUCT_W-1:0] a_ff, a_in;
   logic [MUL_B_W-1:0]   b_ff, b_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         a_in    = PRODUCT_W'(mul_a);
         b_in    = mul_b;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in   = a_ff << 1;
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntW'(MUL_B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

/* rtl/svr_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module svr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        accepted,
   input logic        enable_out,
   input logic        direction_out,
   input logic        pulse_running,
   input logic        tick_running,
   input logic [31:0] period_reload,
   input logic [30:0] pulse_compare,
   input logic [15:0] speed_rpm
);

   logic [83:0] rsp_payload;

   assign rsp_payload = {accepted, enable_out, direction_out, pulse_running, tick_running,
                         period_reload, pulse_compare, speed_rpm};

   // A stalled response item keeps its contents.
   `SVR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_payload), "response changed while stalled")

   `SVR_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid,
                    "response valid right after reset")

   // A target is only taken while the driver is enabled.
   `SVR_ASSERT_IMPLY(a_accept_enabled, clock, reset, rsp_valid && accepted, enable_out,
                     "target accepted while disabled")

   // Ticks only run under running pulses on an enabled driver.
   `SVR_ASSERT_IMPLY(a_tick_needs_pulse, clock, reset, rsp_valid && tick_running,
                     pulse_running && enable_out, "ticks without pulses")

   // Both timer values come from the same period.
   `SVR_ASSERT_IMPLY(a_compare_half, clock, reset, rsp_valid,
                     pulse_compare == 31'((period_reload >> 1) - 32'(!period_reload[0])),
                     "compare not half of period")

endmodule

bind stepper_velocity_ramp_unit svr_checker u_svr_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .accepted      (rsp_chan.accepted),
   .enable_out    (rsp_chan.enable_out),
   .direction_out (rsp_chan.direction_out),
   .pulse_running (rsp_chan.pulse_running),
   .tick_running  (rsp_chan.tick_running),
   .period_reload (rsp_chan.period_reload),
   .pulse_compare (rsp_chan.pulse_compare),
   .speed_rpm     (rsp_chan.speed_rpm)
);
